>>> sv/lbs_pkg.sv
// Shared types and constants for the linear blend skinning block.
// No dependencies; every other file but lbs_ram imports this package.
package lbs_pkg;

    localparam int JOINT_COUNT_DEF = 256;
    localparam int INFLUENCES      = 4;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SKIN = 1'b1;

    typedef logic signed [31:0] word_t;
    typedef word_t [2:0]        row_t;   // one matrix row, columns 0..2
    typedef row_t  [3:0]        mat_t;   // rows 0..2 basis, row 3 translation

    typedef struct packed {
        logic                mode;
        logic [7:0]          matrix_slot;
        logic [1:0]          matrix_row;
        logic signed [31:0]  val_x;
        logic signed [31:0]  val_y;
        logic signed [31:0]  val_z;
        logic [31:0]         joint_indices;
        logic signed [15:0]  weight_0;
        logic signed [15:0]  weight_1;
        logic signed [15:0]  weight_2;
        logic signed [15:0]  weight_3;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } out_t;

    typedef struct packed {
        logic               active;   // positive weight and joint in range
        logic signed [15:0] weight;
        mat_t               mat;
    } infl_t;

    typedef struct packed {
        word_t [2:0]             pos;
        infl_t [INFLUENCES-1:0]  infl;
    } vtx_t;

    typedef struct packed {
        logic vld;
        vtx_t data;
    } qpush_t;

endpackage

>>> sv/lbs_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lbs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/lbs_front.sv
// Front end: accepts requests, writes matrix rows, fetches the four joint
// matrices of a vertex and hands the gathered vertex to the queue. Uses lbs_pkg, lbs_ram.
module lbs_front #(
    parameter int JOINT_COUNT = lbs_pkg::JOINT_COUNT_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              s_valid,
    output logic                                              s_ready,
    input  lbs_pkg::in_t                                      s_data,
    input  logic [$clog2(lbs_pkg::QUEUE_DEPTH+1)-1:0]         q_count,
    output lbs_pkg::qpush_t                                   q_push
);
    import lbs_pkg::*;

    localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic               accept;
    logic               vld_reg;
    word_t [2:0]        pos_reg;
    logic [3:0]         active_reg;
    logic signed [15:0] weight_reg [INFLUENCES];
    logic signed [15:0] w_in [INFLUENCES];
    logic [7:0]         joint [INFLUENCES];
    logic               slot_ok;
    row_t               rd_row [INFLUENCES][4];

    // room for this request plus the one already fetching
    assign s_ready = ({1'b0, q_count} + (CW+1)'(vld_reg)) < (CW+1)'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;
    assign slot_ok = 32'(s_data.matrix_slot) < JOINT_COUNT;

    assign w_in[0] = s_data.weight_0;
    assign w_in[1] = s_data.weight_1;
    assign w_in[2] = s_data.weight_2;
    assign w_in[3] = s_data.weight_3;

    // one RAM per influence and row, load rows written into all four copies
    for (genvar i = 0; i < INFLUENCES; i++) begin : g_infl
        assign joint[i] = s_data.joint_indices[8*i +: 8];
        for (genvar r = 0; r < 4; r++) begin : g_row
            lbs_ram #(.WIDTH($bits(row_t)), .DEPTH(JOINT_COUNT)) u_ram (
                .aclk  (aclk),
                .we    (accept && s_data.mode == MODE_LOAD && slot_ok
                        && s_data.matrix_row == 2'(r)),
                .waddr (s_data.matrix_slot[AW-1:0]),
                .wdata ({s_data.val_z, s_data.val_y, s_data.val_x}),
                .raddr (joint[i][AW-1:0]),
                .rdata (rd_row[i][r])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= accept && s_data.mode == MODE_SKIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg <= {s_data.val_z, s_data.val_y, s_data.val_x};
            for (int i = 0; i < INFLUENCES; i++) begin
                weight_reg[i] <= w_in[i];
                active_reg[i] <= !w_in[i][15] && (w_in[i] != 16'sd0)
                                 && (32'(joint[i]) < JOINT_COUNT);
            end
        end
    end

    always_comb begin
        q_push.vld      = vld_reg;
        q_push.data.pos = pos_reg;
        for (int i = 0; i < INFLUENCES; i++) begin
            q_push.data.infl[i].active = active_reg[i];
            q_push.data.infl[i].weight = weight_reg[i];
            for (int r = 0; r < 4; r++) begin
                q_push.data.infl[i].mat[r] = rd_row[i][r];
            end
        end
    end
endmodule

>>> sv/lbs_queue.sv
// Short FIFO of gathered vertices between front and back end.
// Uses lbs_pkg.
module lbs_queue (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  lbs_pkg::qpush_t                           push,
    input  logic                                      pop,
    output lbs_pkg::vtx_t                             head,
    output logic [$clog2(lbs_pkg::QUEUE_DEPTH+1)-1:0] count
);
    import lbs_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    vtx_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.vld) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.vld && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push.vld) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.vld) begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end
endmodule

>>> sv/lbs_back.sv
// Back end: four-stage skinning datapath (products, row sums, weighting,
// blend and saturate) with the result register. Uses lbs_pkg.
module lbs_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  lbs_pkg::vtx_t head,
    input  logic          head_vld,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output lbs_pkg::out_t m_data
);
    import lbs_pkg::*;

    localparam logic signed [52:0] SAT_MAX = 53'sd2147483647;
    localparam logic signed [52:0] SAT_MIN = -53'sd2147483648;

    logic adv;

    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg;
    logic signed [63:0] prod_next [INFLUENCES][3][3];
    logic signed [63:0] prod_reg  [INFLUENCES][3][3];
    logic signed [31:0] trans_reg [INFLUENCES][3];
    logic signed [15:0] w1_reg [INFLUENCES], w2_reg [INFLUENCES];
    logic [3:0]         act1_reg, act2_reg;
    logic signed [49:0] t_next [INFLUENCES][3];
    logic signed [49:0] t_reg  [INFLUENCES][3];
    logic signed [65:0] tw     [INFLUENCES][3];
    logic signed [50:0] term_next [INFLUENCES][3];
    logic signed [50:0] term_reg  [INFLUENCES][3];
    logic signed [52:0] sum [3];
    logic signed [31:0] sat [3];
    out_t               out_reg;

    // whole pipeline moves together while the result register can drain
    assign adv     = !out_vld_reg || m_ready;
    assign pop     = adv && head_vld;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_comb begin
        for (int i = 0; i < INFLUENCES; i++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_next[i][r][c] = head.pos[r] * head.infl[i].mat[r][c];
                end
            end
        end
    end

    // floor by 2^16 is an arithmetic drop of the low 16 bits
    always_comb begin
        for (int i = 0; i < INFLUENCES; i++) begin
            for (int c = 0; c < 3; c++) begin
                t_next[i][c] = 50'($signed(prod_reg[i][0][c][63:16]))
                             + 50'($signed(prod_reg[i][1][c][63:16]))
                             + 50'($signed(prod_reg[i][2][c][63:16]))
                             + 50'(trans_reg[i][c]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < INFLUENCES; i++) begin
            for (int c = 0; c < 3; c++) begin
                tw[i][c]        = t_reg[i][c] * w2_reg[i];
                term_next[i][c] = act2_reg[i] ? tw[i][c][65:15] : '0;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = 53'(term_reg[0][c]) + 53'(term_reg[1][c])
                   + 53'(term_reg[2][c]) + 53'(term_reg[3][c]);
            if (sum[c] > SAT_MAX) begin
                sat[c] = 32'h7fff_ffff;
            end else if (sum[c] < SAT_MIN) begin
                sat[c] = 32'h8000_0000;
            end else begin
                sat[c] = sum[c][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg  <= head_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            for (int i = 0; i < INFLUENCES; i++) begin
                for (int c = 0; c < 3; c++) begin
                    trans_reg[i][c] <= head.infl[i].mat[3][c];
                end
                w1_reg[i]   <= head.infl[i].weight;
                act1_reg[i] <= head.infl[i].active;
            end
            t_reg    <= t_next;
            w2_reg   <= w1_reg;
            act2_reg <= act1_reg;
            term_reg <= term_next;
            out_reg.out_x <= sat[0];
            out_reg.out_y <= sat[1];
            out_reg.out_z <= sat[2];
        end
    end
endmodule

>>> sv/linear_blend_vertex_skinning_top.sv
// Top level of the linear blend skinning block: front end, vertex queue, back end.
// Uses lbs_pkg, lbs_front, lbs_queue, lbs_back.
//
// One request per clock while s_ready is high. A load request (mode 0) writes
// one 3-word matrix row for joint matrix_slot; slots at or above JOINT_COUNT
// are dropped. A skin request (mode 1) yields one saturated Q16.16 position:
// the matrix fetch is a registered RAM read, then the vertex passes a 4-entry
// queue and a 4-stage datapath. Rows are held in 16 RAMs of JOINT_COUNT x 96
// bits (one per influence and row), so all four joint matrices are read
// together; the queue and the result register let input and output stall
// independently. Matrix rows read before they were ever loaded give undefined
// results.
module linear_blend_vertex_skinning_top #(
    parameter int JOINT_COUNT = lbs_pkg::JOINT_COUNT_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lbs_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lbs_pkg::out_t m_data
);
    import lbs_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    qpush_t        q_push;
    vtx_t          q_head;
    logic [CW-1:0] q_count;
    logic          q_pop;

    lbs_front #(.JOINT_COUNT(JOINT_COUNT)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_count (q_count),
        .q_push  (q_push)
    );

    lbs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .pop     (q_pop),
        .head    (q_head),
        .count   (q_count)
    );

    lbs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .head_vld (q_count != '0),
        .pop      (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("vertex queue over capacity");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == CW'(QUEUE_DEPTH)) |-> (!q_push.vld || q_pop))
        else $error("push into full vertex queue");

    a_load_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_LOAD) |=> !q_push.vld)
        else $error("load request produced a vertex");

    a_skin_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_SKIN) |=> q_push.vld)
        else $error("skin request lost before queue");
endmodule
